// ===== rtl/core/acet_pkg.sv =====
// Shared types and constants for the advertising channel event timer.
// No dependencies; used by the channel interfaces, the core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package acet_pkg;

    localparam int CH_W     = 6;
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 14;
    localparam int MASK_W   = 3;
    localparam int IVL_W    = 24;
    localparam int GAP_W    = 16;
    localparam int STEP_W   = 25;   // interval plus reduced delay, never above 2^25
    localparam int CFG_W    = 24;
    localparam int CFG_IX_W = 2;

    localparam logic [CFG_IX_W-1:0] REG_CHANNEL_MASK   = 2'd0;
    localparam logic [CFG_IX_W-1:0] REG_EVENT_INTERVAL = 2'd1;
    localparam logic [CFG_IX_W-1:0] REG_PDU_GAP        = 2'd2;

    localparam logic [MASK_W-1:0] MASK_RESET     = 3'd7;
    localparam logic [IVL_W-1:0]  INTERVAL_RESET = 24'd1280000;
    localparam logic [GAP_W-1:0]  GAP_RESET      = 16'd10000;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_TX_DONE = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [TIME_W-1:0] pdu_start_time;
        logic              new_event;
        logic              late;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/acet_if.sv =====
// Valid/ready channel interfaces for the advertising channel event timer.
// Depends on acet_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface acet_in_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [acet_pkg::TIME_W-1:0]     now_time;
    logic [acet_pkg::DELAY_W-1:0]    random_delay;

    modport source (output valid, output mode, output now_time, output random_delay,
                    input ready);
    modport sink   (input valid, input mode, input now_time, input random_delay,
                    output ready);
endinterface

interface acet_out_if;
    logic                            valid;
    logic                            ready;
    logic [acet_pkg::CH_W-1:0]       channel;
    logic [acet_pkg::TIME_W-1:0]     pdu_start_time;
    logic                            new_event;
    logic                            late;

    modport source (output valid, output channel, output pdu_start_time,
                    output new_event, output late, input ready);
    modport sink   (input valid, input channel, input pdu_start_time,
                    input new_event, input late, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/adv_channel_event_timer_unit.sv =====
// Advertising channel event timer: channel and PDU time sequencer.
// Depends on acet_pkg and the channel interfaces in acet_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Payload                                      | Handshake
// in_ch    | in  | mode, now_time, random_delay                 | valid/ready
// out_ch   | out | channel, pdu_start_time, new_event, late     | valid/ready
// cfg      | in  | cfg_we, cfg_index, cfg_data                  | write enable only
//
// One 33-bit adder serves every add, compare and remainder step under the sequencer.
// A start runs S_STEP and S_CALC, a tx-done also S_CHK; the result is registered on
// leaving S_DONE, as in_ch.ready rises. S_DMOD and S_DSUB run first when random_delay
// >= MAX_RANDOM_DELAY (constant reciprocal multiply, then subtract); a late tx-done runs
// catch-up (32-step remainder and 4 adds). in_ch.ready is high only while idle; a result
// held by out_ch stalls the next result but not the next accept. Reset is immediate.

module adv_channel_event_timer_unit #(
    parameter int FIRST_ADV_CHANNEL = 37,
    parameter int MAX_RANDOM_DELAY  = 10000
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    acet_in_if.sink                             in_ch,
    acet_out_if.source                          out_ch,
    input  wire                                 cfg_we,
    input  wire  [acet_pkg::CFG_IX_W-1:0]       cfg_index,
    input  wire  [acet_pkg::CFG_W-1:0]          cfg_data
);

    localparam int CH_W    = acet_pkg::CH_W;
    localparam int TIME_W  = acet_pkg::TIME_W;
    localparam int DELAY_W = acet_pkg::DELAY_W;
    localparam int STEP_W  = acet_pkg::STEP_W;
    localparam int CNT_W   = 6;
    localparam int RCP_W   = DELAY_W + 1;
    localparam int DPROD_W = DELAY_W + RCP_W;
    localparam int DLY_SH  = DELAY_W + $clog2(MAX_RANDOM_DELAY);

    localparam logic [CH_W-1:0] CH0 = CH_W'(FIRST_ADV_CHANNEL);
    localparam logic [CH_W-1:0] CH1 = CH_W'(FIRST_ADV_CHANNEL + 1);
    localparam logic [CH_W-1:0] CH2 = CH_W'(FIRST_ADV_CHANNEL + 2);
    localparam logic [TIME_W-1:0] DELAY_LIM = TIME_W'(MAX_RANDOM_DELAY);
    // exact quotient for any 14-bit delay: ceil(2^DLY_SH / MAX_RANDOM_DELAY)
    localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << DLY_SH)
        + 64'(MAX_RANDOM_DELAY) - 64'd1) / 64'(MAX_RANDOM_DELAY));

    typedef enum logic [3:0] {
        S_IDLE, S_DMOD, S_DSUB, S_STEP, S_CALC, S_CHK, S_NEG, S_BDIV, S_PAD, S_TOT, S_ADV,
        S_DONE
    } state_t;

    // configuration
    logic [acet_pkg::MASK_W-1:0] mask_reg;
    logic [acet_pkg::IVL_W-1:0]  interval_reg;
    logic [acet_pkg::GAP_W-1:0]  gap_reg;

    // sequencer, architectural state and result
    state_t              state_reg, state_next;
    logic [CH_W-1:0]     cur_ch_reg, cur_ch_next;
    logic [TIME_W-1:0]   est_reg, est_next;
    logic [TIME_W-1:0]   npt_reg, npt_next;
    logic                out_valid_reg, out_valid_next;
    acet_pkg::result_t   res_reg, res_next;

    // working registers
    logic                mode_reg, mode_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [DELAY_W-1:0]  dq_reg, dq_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                ne_reg, ne_next;
    logic                late_reg, late_next;
    logic [TIME_W-1:0]   behind_reg, behind_next;
    logic [TIME_W-1:0]   tmp_reg, tmp_next;
    logic [STEP_W-1:0]   rem_reg, rem_next;
    logic [TIME_W-1:0]   dvd_reg, dvd_next;
    logic [STEP_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // shared adder
    logic [TIME_W-1:0]   add_a, add_b;
    logic                add_cin;
    logic [TIME_W:0]     sum;

    logic [CH_W-1:0]     first_ch, last_ch, step_ch, step_off;
    logic                step_en;
    logic [STEP_W:0]     trial;
    logic [DPROD_W-1:0]  dprod;
    logic [TIME_W-1:0]   dq_prod;

    always_comb
    begin
        first_ch = mask_reg[0] ? CH0 : (mask_reg[1] ? CH1 : CH2);
        last_ch  = mask_reg[2] ? CH2 : (mask_reg[1] ? CH1 : CH0);
        step_ch  = cur_ch_reg + 6'd1;
        step_off = step_ch - CH0;
        step_en  = (step_off <= 6'd2) && mask_reg[step_off[1:0]];
        trial    = {rem_reg, dvd_reg[TIME_W-1]};
        dprod    = DPROD_W'(delay_reg) * DPROD_W'(RCP);
        dq_prod  = TIME_W'(dq_reg) * DELAY_LIM;
    end

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            S_DSUB:
            begin
                add_a   = TIME_W'(delay_reg);
                add_b   = ~dq_prod;
                add_cin = 1'b1;
            end
            S_BDIV:
            begin
                add_a   = TIME_W'(trial);
                add_b   = ~TIME_W'(div_reg);
                add_cin = 1'b1;
            end
            S_STEP:
            begin
                add_a = TIME_W'(interval_reg);
                add_b = TIME_W'(delay_reg);
            end
            S_CALC:
            begin
                if (cur_ch_reg == last_ch)
                begin
                    add_a = est_reg;
                    add_b = TIME_W'(step_reg);
                end
                else
                begin
                    add_a = npt_reg;
                    add_b = TIME_W'(gap_reg);
                end
            end
            S_CHK:
            begin
                add_a   = npt_reg;
                add_b   = ~now_reg;
                add_cin = 1'b1;
            end
            S_NEG:
            begin
                add_a   = now_reg;
                add_b   = ~npt_reg;
                add_cin = 1'b1;
            end
            S_PAD:
            begin
                add_a   = TIME_W'(step_reg);
                add_b   = ~TIME_W'(rem_reg);
                add_cin = 1'b1;
            end
            S_TOT:
            begin
                add_a = behind_reg;
                add_b = tmp_reg;
            end
            S_ADV:
            begin
                add_a = est_reg;
                add_b = tmp_reg;
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
        sum = {1'b0, add_a} + {1'b0, add_b} + {{TIME_W{1'b0}}, add_cin};
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_ch_next    = cur_ch_reg;
        est_next       = est_reg;
        npt_next       = npt_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        mode_next      = mode_reg;
        now_next       = now_reg;
        delay_next     = delay_reg;
        dq_next        = dq_reg;
        step_next      = step_reg;
        ne_next        = ne_reg;
        late_next      = late_reg;
        behind_next    = behind_reg;
        tmp_next       = tmp_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    mode_next  = in_ch.mode;
                    now_next   = in_ch.now_time;
                    delay_next = in_ch.random_delay;
                    ne_next    = 1'b0;
                    late_next  = 1'b0;
                    if (TIME_W'(in_ch.random_delay) >= DELAY_LIM)
                    begin
                        state_next = S_DMOD;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_DMOD:
            begin
                dq_next    = DELAY_W'(dprod >> DLY_SH);
                state_next = S_DSUB;
            end
            S_DSUB:
            begin
                delay_next = sum[DELAY_W-1:0];
                state_next = S_STEP;
            end
            S_BDIV:
            begin
                // restoring remainder, one dividend bit per cycle
                rem_next = sum[TIME_W] ? sum[STEP_W-1:0] : trial[STEP_W-1:0];
                dvd_next = {dvd_reg[TIME_W-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = S_PAD;
                end
            end
            S_STEP:
            begin
                step_next  = sum[STEP_W-1:0];
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (mode_reg == acet_pkg::MODE_START)
                begin
                    cur_ch_next = first_ch;
                    est_next    = now_reg;
                    npt_next    = now_reg;
                    ne_next     = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    if (cur_ch_reg == last_ch)
                    begin
                        cur_ch_next = first_ch;
                        est_next    = sum[TIME_W-1:0];
                        npt_next    = sum[TIME_W-1:0];
                        ne_next     = 1'b1;
                    end
                    else
                    begin
                        // a disabled or out-of-range channel is skipped once
                        cur_ch_next = step_en ? step_ch : step_ch + 6'd1;
                        npt_next    = sum[TIME_W-1:0];
                    end
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                state_next = S_DONE;
                if (sum[TIME_W-1])
                begin
                    late_next   = 1'b1;
                    ne_next     = 1'b1;
                    cur_ch_next = first_ch;
                    if (step_reg != '0)
                    begin
                        state_next = S_NEG;
                    end
                end
            end
            S_NEG:
            begin
                behind_next = sum[TIME_W-1:0];
                dvd_next    = sum[TIME_W-1:0];
                rem_next    = '0;
                div_next    = step_reg;
                cnt_next    = CNT_W'(TIME_W);
                state_next  = S_BDIV;
            end
            S_PAD:
            begin
                // rounds behind up to a whole number of steps
                tmp_next   = (rem_reg == '0) ? '0 : sum[TIME_W-1:0];
                state_next = S_TOT;
            end
            S_TOT:
            begin
                tmp_next   = sum[TIME_W-1:0];
                state_next = S_ADV;
            end
            S_ADV:
            begin
                est_next   = sum[TIME_W-1:0];
                npt_next   = sum[TIME_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    res_next.channel        = cur_ch_reg;
                    res_next.pdu_start_time = npt_reg;
                    res_next.new_event      = ne_reg;
                    res_next.late           = late_reg;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_ch_reg    <= CH0;
            est_reg       <= '0;
            npt_reg       <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_ch_reg    <= cur_ch_next;
            est_reg       <= est_next;
            npt_reg       <= npt_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= acet_pkg::MASK_RESET;
            interval_reg <= acet_pkg::INTERVAL_RESET;
            gap_reg      <= acet_pkg::GAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                acet_pkg::REG_CHANNEL_MASK:   mask_reg     <= cfg_data[acet_pkg::MASK_W-1:0];
                acet_pkg::REG_EVENT_INTERVAL: interval_reg <= cfg_data[acet_pkg::IVL_W-1:0];
                acet_pkg::REG_PDU_GAP:        gap_reg      <= cfg_data[acet_pkg::GAP_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        now_reg    <= now_next;
        delay_reg  <= delay_next;
        dq_reg     <= dq_next;
        step_reg   <= step_next;
        ne_reg     <= ne_next;
        late_reg   <= late_next;
        behind_reg <= behind_next;
        tmp_reg    <= tmp_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        div_reg    <= div_next;
        cnt_reg    <= cnt_next;
    end

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.channel        = res_reg.channel;
    assign out_ch.pdu_start_time = res_reg.pdu_start_time;
    assign out_ch.new_event      = res_reg.new_event;
    assign out_ch.late           = res_reg.late;

endmodule

`default_nettype wire

// ===== rtl/core/acet_checker.sv =====
// Port-level checker for the advertising channel event timer, bound to the top.
// Depends on acet_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module acet_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_valid,
    input wire                          in_ready,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire [acet_pkg::CH_W-1:0]     channel,
    input wire                          new_event,
    input wire                          late
);

    // one transaction at a time: no accept right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(channel) && $stable(new_event) && $stable(late)))
        else $error("result changed while stalled");

    a_late_new_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && late) |-> new_event)
        else $error("late result without new event");

endmodule

bind adv_channel_event_timer_unit acet_checker u_acet_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .channel   (out_ch.channel),
    .new_event (out_ch.new_event),
    .late      (out_ch.late)
);

`default_nettype wire
